@@ rtl/double_ended_queue_unit_macros.svh @@
// Assertion macros shared by the queue unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Check that a consequent holds in the same cycle as its trigger.
`define DQ_ASSERT_IMPLIES(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cons)) \
        else $error("dq: same-cycle check failed");

// Check that a consequent holds in the cycle after its trigger.
`define DQ_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("dq: next-cycle check failed");

`endif

@@ rtl/dq_pkg.sv @@
package dq_pkg;

    localparam int DQ_CAPACITY = 32;
    localparam int DQ_ITEM_W   = 32;

    typedef logic [2:0] mode_t;
    typedef logic [1:0] status_t;

    // Request codes
    localparam mode_t MODE_PUSH_FRONT = 3'd0;
    localparam mode_t MODE_PUSH_BACK  = 3'd1;
    localparam mode_t MODE_POP_FRONT  = 3'd2;
    localparam mode_t MODE_POP_BACK   = 3'd3;
    localparam mode_t MODE_LIST_FWD   = 3'd4;
    localparam mode_t MODE_LIST_BWD   = 3'd5;

    // Result status codes
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    push;
        logic    pop;
        logic    front_end;    // push/pop at front, or list front to back
        logic    list_start;
        logic    list_step;
        logic    load_status;
        status_t status;
    } dq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
        logic out_free;
    } dq_sts_t;

endpackage

@@ rtl/dq_ctrl.sv @@
module dq_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dq_pkg::mode_t   s_mode,
    output dq_pkg::dq_cmd_t cmd,
    input  dq_pkg::dq_sts_t sts
);
    import dq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode requests and sequence listings
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = sts.out_free;
                if (s_valid && sts.out_free) begin
                    unique case (s_mode) inside
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            cmd.load_status = 1'b1;
                            cmd.front_end   = (s_mode == MODE_PUSH_FRONT);
                            if (sts.full) begin
                                cmd.status = STATUS_FULL;
                            end else begin
                                cmd.push   = 1'b1;
                                cmd.status = STATUS_OK;
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK: begin
                            cmd.load_status = 1'b1;
                            cmd.front_end   = (s_mode == MODE_POP_FRONT);
                            if (sts.empty) begin
                                cmd.status = STATUS_EMPTY;
                            end else begin
                                cmd.pop    = 1'b1;
                                cmd.status = STATUS_OK;
                            end
                        end
                        MODE_LIST_FWD, MODE_LIST_BWD: begin
                            cmd.front_end = (s_mode == MODE_LIST_FWD);
                            if (sts.empty) begin
                                cmd.load_status = 1'b1;
                                cmd.status      = STATUS_EMPTY;
                            end else begin
                                cmd.list_start = 1'b1;
                                state_next     = ST_LIST;
                            end
                        end
                        default: begin
                            // drop unused codes
                        end
                    endcase
                end
            end
            ST_LIST: begin
                if (sts.out_free) begin
                    cmd.list_step = 1'b1;
                    if (sts.list_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/dq_dp.sv @@
module dq_dp #(
    parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dq_pkg::dq_cmd_t                     cmd,
    output dq_pkg::dq_sts_t                     sts,
    input  logic signed [dq_pkg::DQ_ITEM_W-1:0] s_item_in,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic signed [dq_pkg::DQ_ITEM_W-1:0] m_item_out,
    output logic                                m_carries_item,
    output dq_pkg::status_t                     m_status,
    output logic                                m_last_of_run
);
    import dq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] SUM_CAP  = SUM_W'(CAPACITY);

    logic [DQ_ITEM_W-1:0] ring_mem [CAPACITY];
    logic [DQ_ITEM_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] ptr_reg;
    logic [CNT_W-1:0] remain_reg;
    logic             fwd_reg;
    logic             valid_reg;
    logic             valid_next;

    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] ptr_inc;
    logic [IDX_W-1:0] ptr_dec;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] back_sum;
    logic [IDX_W-1:0] tail_slot;
    logic [IDX_W-1:0] back_slot;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // Wrap the ring indexes
    assign front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
    assign ptr_inc   = (ptr_reg == IDX_LAST) ? '0 : ptr_reg + 1'b1;
    assign ptr_dec   = (ptr_reg == '0) ? IDX_LAST : ptr_reg - 1'b1;

    // Locate the slot past the back and the back slot itself
    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_sum  = tail_sum - SUM_W'(1);
    assign tail_slot = (tail_sum >= SUM_CAP) ? IDX_W'(tail_sum - SUM_CAP) : IDX_W'(tail_sum);
    assign back_slot = (back_sum >= SUM_CAP) ? IDX_W'(back_sum - SUM_CAP) : IDX_W'(back_sum);

    // Status to the controller
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CNT_FULL);
    assign sts.list_last = (remain_reg == CNT_W'(1));
    assign sts.out_free  = !valid_reg || m_ready;

    // Select memory addresses
    assign wr_en   = cmd.push;
    assign wr_addr = cmd.front_end ? front_dec : tail_slot;
    assign rd_en   = cmd.list_start || (cmd.list_step && !sts.list_last);
    always_comb begin
        if (cmd.list_start) begin
            rd_addr = cmd.front_end ? front_reg : back_slot;
        end else begin
            rd_addr = fwd_reg ? ptr_inc : ptr_dec;
        end
    end

    // Ring store with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= s_item_in;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Advance front index and count
    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + 1'b1;
            if (cmd.front_end) begin
                front_next = front_dec;
            end
        end else if (cmd.pop) begin
            count_next = count_reg - 1'b1;
            if (cmd.front_end) begin
                front_next = front_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Track the listing walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
        end else if (cmd.list_start) begin
            remain_reg <= count_reg;
        end else if (cmd.list_step) begin
            remain_reg <= remain_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.list_start) begin
            fwd_reg <= cmd.front_end;
        end
        if (rd_en) begin
            ptr_reg <= rd_addr;
        end
    end

    // Hold the result until it is taken
    always_comb begin
        valid_next = valid_reg;
        if (cmd.load_status || cmd.list_step) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_status) begin
            m_item_out     <= '0;
            m_carries_item <= 1'b0;
            m_status       <= cmd.status;
            m_last_of_run  <= 1'b1;
        end else if (cmd.list_step) begin
            m_item_out     <= rd_data_reg;
            m_carries_item <= 1'b1;
            m_status       <= STATUS_OK;
            m_last_of_run  <= sts.list_last;
        end
    end

    assign m_valid = valid_reg;

endmodule

@@ rtl/double_ended_queue_unit.sv @@
// Bounded double-ended queue of signed 32-bit values held in a ring store of
// CAPACITY entries. Each request names one of six operations on s_mode: push
// front, push back, pop front, pop back, list front to back, list back to
// front. A push or pop returns one status result (ok, empty, or full with the
// push dropped), and these requests are accepted every cycle while results are
// drained. A listing returns one result per stored value with m_last_of_run on
// the final one, or a single empty result on an empty queue; it holds off new
// requests until its last result is loaded, as values come one at a time from
// the one registered read port of the ring store. Unused mode codes are dropped
// without a result. Store contents need no clearing after reset.
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit #(
    parameter int CAPACITY = dq_pkg::DQ_CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dq_pkg::mode_t                       s_mode,
    input  logic signed [dq_pkg::DQ_ITEM_W-1:0] s_item_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [dq_pkg::DQ_ITEM_W-1:0] m_item_out,
    output logic                                m_carries_item,
    output dq_pkg::status_t                     m_status,
    output logic                                m_last_of_run
);
    import dq_pkg::*;

    dq_cmd_t cmd;
    dq_sts_t sts;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .cmd     (cmd),
        .sts     (sts)
    );

    dq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_item_in      (s_item_in),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_item_out     (m_item_out),
        .m_carries_item (m_carries_item),
        .m_status       (m_status),
        .m_last_of_run  (m_last_of_run)
    );

    // A status result never carries a value and always closes its request
    `DQ_ASSERT_IMPLIES(a_status_closes, m_valid && (m_status != STATUS_OK), !m_carries_item && m_last_of_run)

    // Block new requests while a listing is still running
    `DQ_ASSERT_IMPLIES(a_list_blocks, m_valid && m_carries_item && !m_last_of_run, !s_ready)

    // A drained listing entry is followed at once by the next one
    `DQ_ASSERT_NEXT(a_list_streams, m_valid && m_ready && m_carries_item && !m_last_of_run, m_valid && m_carries_item)

    // A push into a queue with room reports ok
    `DQ_ASSERT_NEXT(a_push_ok, s_valid && s_ready && !sts.full && ((s_mode == MODE_PUSH_FRONT) || (s_mode == MODE_PUSH_BACK)), m_valid && (m_status == STATUS_OK))

endmodule

@@ dv/double_ended_queue_unit_test.sv @@
module double_ended_queue_unit_test;

    import dq_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_OFF       = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_REQUESTS = 55;

    // Mode codes the block drops without a result
    localparam mode_t MODE_UNUSED_LO = 3'd6;
    localparam mode_t MODE_UNUSED_HI = 3'd7;

    typedef logic signed [DQ_ITEM_W-1:0] item_t;

    typedef struct packed {
        item_t   item_out;
        logic    carries_item;
        status_t status;
        logic    last_of_run;
    } dq_result_t;

    logic  aclk           = 1'b0;
    logic  aresetn        = 1'b0;
    logic  s_valid        = 1'b0;
    logic  s_ready;
    mode_t s_mode         = MODE_PUSH_FRONT;
    item_t s_item_in      = '0;
    logic  m_valid;
    logic  m_ready        = 1'b0;
    item_t m_item_out;
    logic  m_carries_item;
    status_t m_status;
    logic  m_last_of_run;

    // Shadow deque contents and the results they imply
    item_t      queue_contents[$];
    dq_result_t pending_results[$];
    dq_result_t want_result;

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int quiet_cycles   = 0;

    always #2 aclk = ~aclk;

    double_ended_queue_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_item_in      (s_item_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item_out     (m_item_out),
        .m_carries_item (m_carries_item),
        .m_status       (m_status),
        .m_last_of_run  (m_last_of_run)
    );

    function automatic dq_result_t result_of(input item_t item, input logic carries,
                                             input status_t st, input logic last);
        dq_result_t r;
        r.item_out     = item;
        r.carries_item = carries;
        r.status       = st;
        r.last_of_run  = last;
        return r;
    endfunction

    // Apply one accepted request to the shadow deque and queue its results
    task automatic predict_request(input mode_t mode, input item_t value);
        int n;
        int idx;
        begin
            n = queue_contents.size();
            case (mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                    if (n >= DQ_CAPACITY) begin
                        pending_results.push_back(result_of('0, 1'b0, STATUS_FULL, 1'b1));
                    end else begin
                        if (mode == MODE_PUSH_FRONT) queue_contents.push_front(value);
                        else queue_contents.push_back(value);
                        pending_results.push_back(result_of('0, 1'b0, STATUS_OK, 1'b1));
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK: begin
                    if (n == 0) begin
                        pending_results.push_back(result_of('0, 1'b0, STATUS_EMPTY, 1'b1));
                    end else begin
                        if (mode == MODE_POP_FRONT) void'(queue_contents.pop_front());
                        else void'(queue_contents.pop_back());
                        pending_results.push_back(result_of('0, 1'b0, STATUS_OK, 1'b1));
                    end
                end
                MODE_LIST_FWD, MODE_LIST_BWD: begin
                    if (n == 0) begin
                        pending_results.push_back(result_of('0, 1'b0, STATUS_EMPTY, 1'b1));
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            idx = (mode == MODE_LIST_FWD) ? i : n - 1 - i;
                            pending_results.push_back(result_of(queue_contents[idx], 1'b1,
                                                                STATUS_OK, i == n - 1));
                        end
                    end
                end
                default: ;
            endcase
        end
    endtask

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input mode_t mode, input item_t value);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid   <= 1'b1;
            s_mode    <= mode;
            s_item_in <= value;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            predict_request(mode, value);
        end
    endtask

    // Drop valid, wait for every pending result, then let the block settle
    task automatic wait_drained();
        begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (pending_results.size() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end
    endtask

    function automatic item_t pick_value();
        case ($urandom_range(9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic mode_t pick_mode(input int push_w, input int pop_w);
        int r;
        r = $urandom_range(99);
        if (r < 3) return $urandom_range(1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
        if (r < 3 + push_w) return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        if (r < 3 + push_w + pop_w) return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
        return $urandom_range(1) ? MODE_LIST_BWD : MODE_LIST_FWD;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("mismatch: %s got %0h want %0h", what, got, want);
            error_count++;
        end
    endtask

    // Receiver: long hold-off when requested, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_item_out, '0);
            end else begin
                want_result = pending_results.pop_front();
                if (m_item_out !== want_result.item_out)
                    report_mismatch("item_out", m_item_out, want_result.item_out);
                if (m_carries_item !== want_result.carries_item)
                    report_mismatch("carries_item", 32'(m_carries_item),
                                    32'(want_result.carries_item));
                if (m_status !== want_result.status)
                    report_mismatch("status", 32'(m_status), 32'(want_result.status));
                if (m_last_of_run !== want_result.last_of_run)
                    report_mismatch("last_of_run", 32'(m_last_of_run),
                                    32'(want_result.last_of_run));
            end
        end
    end

    // Abort when no handshake happens on either side for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     quiet_cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Pops and listings on an empty queue, and the dropped mode codes
    task automatic test_empty_queue();
        begin
            send_idle_pct = 0;
            recv_stall_pct <= 0;
            send_request(MODE_LIST_FWD, pick_value());
            send_request(MODE_LIST_BWD, pick_value());
            send_request(MODE_POP_FRONT, pick_value());
            send_request(MODE_POP_BACK, pick_value());
            send_request(MODE_UNUSED_LO, '1);
            send_request(MODE_UNUSED_HI, '1);
            wait_drained();
        end
    endtask

    // Extreme values at both ends, listed both ways and popped empty again
    task automatic test_extremes();
        begin
            send_request(MODE_PUSH_FRONT, 32'sh7fff_ffff);
            send_request(MODE_PUSH_BACK, 32'sh8000_0000);
            send_request(MODE_PUSH_FRONT, '0);
            send_request(MODE_PUSH_BACK, '1);
            send_request(MODE_LIST_FWD, pick_value());
            send_request(MODE_LIST_BWD, pick_value());
            send_request(MODE_POP_BACK, pick_value());
            send_request(MODE_UNUSED_HI, pick_value());
            send_request(MODE_LIST_FWD, pick_value());
            send_request(MODE_POP_FRONT, pick_value());
            send_request(MODE_LIST_BWD, pick_value());
            send_request(MODE_POP_FRONT, pick_value());
            send_request(MODE_POP_BACK, pick_value());
            send_request(MODE_POP_BACK, pick_value());
            send_request(MODE_LIST_FWD, pick_value());
            wait_drained();
        end
    endtask

    // Random bursts that lean toward filling, draining, or neither
    task automatic test_random_ops(input int count, input int idle_pct, input int stall_pct);
        int    sent;
        int    burst;
        int    push_w;
        int    pop_w;
        mode_t mode;
        begin
            send_idle_pct = idle_pct;
            recv_stall_pct <= stall_pct;
            sent = 0;
            while (sent < count) begin
                burst = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0: begin
                        push_w = 72;
                        pop_w  = 14;
                    end
                    1: begin
                        push_w = 14;
                        pop_w  = 72;
                    end
                    default: begin
                        push_w = 42;
                        pop_w  = 42;
                    end
                endcase
                repeat (burst) begin
                    mode = pick_mode(push_w, pop_w);
                    send_request(mode, pick_value());
                    if (mode <= MODE_LIST_BWD) sent++;
                end
            end
            wait_drained();
        end
    endtask

    // Hold the receiver off while filling the queue past capacity
    task automatic test_backpressure();
        begin
            send_idle_pct = 0;
            recv_stall_pct <= 0;
            hold_cycles <= HOLD_OFF;
            while (queue_contents.size() < DQ_CAPACITY) begin
                send_request($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                             pick_value());
            end
            send_request(MODE_PUSH_FRONT, pick_value());
            send_request(MODE_PUSH_BACK, pick_value());
            send_request(MODE_LIST_FWD, pick_value());
            send_request(MODE_LIST_BWD, pick_value());
            wait_drained();
        end
    endtask

    // Pop from random ends until empty, then once more on each end and list backward
    task automatic test_drain();
        begin
            send_idle_pct = 15;
            recv_stall_pct <= 15;
            while (queue_contents.size() != 0) begin
                send_request($urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT,
                             pick_value());
            end
            send_request(MODE_POP_FRONT, pick_value());
            send_request(MODE_POP_BACK, pick_value());
            send_request(MODE_LIST_BWD, pick_value());
            wait_drained();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_queue();
        test_extremes();
        test_random_ops(PHASE_REQUESTS, 0, 0);
        test_random_ops(PHASE_REQUESTS, 49, 0);
        test_random_ops(PHASE_REQUESTS, 0, 49);
        test_random_ops(PHASE_REQUESTS, 15, 15);
        test_backpressure();
        test_drain();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
